### sv/assert_macros.svh
// Assertion helpers shared by the resizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

### sv/rsz_pkg.sv
// ----------------------------------------------------------------------------
// Image resizer package
// Shared types, register indexes and constants of the resizer.
// ----------------------------------------------------------------------------
package rsz_pkg;

   localparam int unsigned MaxHeight   = 128;
   localparam int unsigned MaxWidth    = 128;
   localparam int unsigned MaxChannels = 4;
   localparam int unsigned OutMax      = 1024;

   localparam logic [2:0] REG_MODE       = 3'd0;
   localparam logic [2:0] REG_IN_HEIGHT  = 3'd1;
   localparam logic [2:0] REG_IN_WIDTH   = 3'd2;
   localparam logic [2:0] REG_CHANNELS   = 3'd3;
   localparam logic [2:0] REG_OUT_HEIGHT = 3'd4;
   localparam logic [2:0] REG_OUT_WIDTH  = 3'd5;
   localparam logic [2:0] REG_STEP_X     = 3'd6;
   localparam logic [2:0] REG_STEP_Y     = 3'd7;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_EMIT = 1'b1;

   localparam logic MODE_NEAREST  = 1'b0;
   localparam logic MODE_BILINEAR = 1'b1;

   // Clamped geometry seen by the back end.
   typedef struct packed {
      logic        mode;
      logic [7:0]  h;
      logic [7:0]  w;
      logic [14:0] hw;
      logic [23:0] step_x;
      logic [23:0] step_y;
   } cfg_type;

   // One command between front and back.
   typedef struct packed {
      logic        is_emit;
      logic        valid;
      logic        last;
      logic [15:0] addr;
      logic [15:0] sample;
      logic [1:0]  ch;
      logic [9:0]  row;
      logic [9:0]  col;
   } cmd_type;

endpackage

### sv/rsz_front.sv
// ----------------------------------------------------------------------------
// Resizer front end
// Holds configuration, load pointer and emit counters; turns each
// accepted transaction into a command for the back end.
// ----------------------------------------------------------------------------
module rsz_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic                 req_action,
   input  logic signed [15:0]   req_sample_in,
   input  logic                 valid,
   output logic                 ready,
   input  logic [2:0]           csr_index,
   input  logic [23:0]          csr_wdata,
   input  logic                 q_full,
   output logic                 q_push,
   output rsz_pkg::cmd_type     q_cmd,
   output rsz_pkg::cfg_type     cfg
);

   logic        mode_ff;
   logic [7:0]  h_raw_ff, w_raw_ff;
   logic [2:0]  c_raw_ff;
   logic [10:0] oh_raw_ff, ow_raw_ff;
   logic [23:0] sx_ff, sy_ff;

   logic [15:0] ptr_ff, ptr_in;
   logic        loaded_ff, loaded_in;
   logic [1:0]  ch_ff, ch_in;
   logic [9:0]  row_ff, row_in;
   logic [9:0]  col_ff, col_in;

   logic [7:0]  h, w;
   logic [2:0]  c;
   logic [10:0] oh, ow;
   logic [15:0] hw_full;
   logic [16:0] total;
   logic        col_end, row_end, ch_end, wr;

   always_comb begin
      h  = (h_raw_ff == 8'd0) ? 8'd1 : (h_raw_ff > 8'(rsz_pkg::MaxHeight)) ?
           8'(rsz_pkg::MaxHeight) : h_raw_ff;
      w  = (w_raw_ff == 8'd0) ? 8'd1 : (w_raw_ff > 8'(rsz_pkg::MaxWidth)) ?
           8'(rsz_pkg::MaxWidth) : w_raw_ff;
      c  = (c_raw_ff == 3'd0) ? 3'd1 : (c_raw_ff > 3'(rsz_pkg::MaxChannels)) ?
           3'(rsz_pkg::MaxChannels) : c_raw_ff;
      oh = (oh_raw_ff == 11'd0) ? 11'd1 : (oh_raw_ff > 11'(rsz_pkg::OutMax)) ?
           11'(rsz_pkg::OutMax) : oh_raw_ff;
      ow = (ow_raw_ff == 11'd0) ? 11'd1 : (ow_raw_ff > 11'(rsz_pkg::OutMax)) ?
           11'(rsz_pkg::OutMax) : ow_raw_ff;
      hw_full = h * w;
      total   = {14'd0, c} * {2'd0, hw_full[14:0]};
   end

   assign cfg.mode   = mode_ff;
   assign cfg.h      = h;
   assign cfg.w      = w;
   assign cfg.hw     = hw_full[14:0];
   assign cfg.step_x = sx_ff;
   assign cfg.step_y = sy_ff;

   assign full   = q_full;
   assign ready  = 1'b1;
   assign wr     = valid;
   assign q_push = push && !q_full;

   assign col_end = ({1'b0, col_ff} == ow - 11'd1);
   assign row_end = ({1'b0, row_ff} == oh - 11'd1);
   assign ch_end  = ({1'b0, ch_ff} == c - 3'd1);

   always_comb begin
      q_cmd.is_emit = (req_action == rsz_pkg::ACT_EMIT);
      q_cmd.valid   = loaded_ff;
      q_cmd.last    = loaded_ff && col_end && row_end && ch_end;
      q_cmd.addr    = ptr_ff;
      q_cmd.sample  = req_sample_in;
      q_cmd.ch      = ch_ff;
      q_cmd.row     = row_ff;
      q_cmd.col     = col_ff;

      ptr_in    = ptr_ff;
      loaded_in = loaded_ff;
      ch_in     = ch_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      if (q_push) begin
         if (req_action == rsz_pkg::ACT_LOAD) begin
            if ({1'b0, ptr_ff} + 17'd1 == total) begin
               ptr_in    = '0;
               loaded_in = 1'b1;
            end else begin
               ptr_in = ptr_ff + 16'd1;
            end
         end else if (loaded_ff) begin
            if (col_end) begin
               col_in = '0;
               if (row_end) begin
                  row_in = '0;
                  ch_in  = ch_end ? 2'd0 : ch_ff + 2'd1;
               end else begin
                  row_in = row_ff + 10'd1;
               end
            end else begin
               col_in = col_ff + 10'd1;
            end
         end
      end
      if (wr) begin
         if (csr_index == rsz_pkg::REG_IN_HEIGHT || csr_index == rsz_pkg::REG_IN_WIDTH ||
             csr_index == rsz_pkg::REG_CHANNELS) begin
            ptr_in    = '0;
            loaded_in = 1'b0;
         end
         if (csr_index == rsz_pkg::REG_CHANNELS || csr_index == rsz_pkg::REG_OUT_HEIGHT ||
             csr_index == rsz_pkg::REG_OUT_WIDTH) begin
            ch_in  = '0;
            row_in = '0;
            col_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= rsz_pkg::MODE_BILINEAR;
         h_raw_ff  <= 8'd2;
         w_raw_ff  <= 8'd2;
         c_raw_ff  <= 3'd1;
         oh_raw_ff <= 11'd1;
         ow_raw_ff <= 11'd1;
         sx_ff     <= 24'd65536;
         sy_ff     <= 24'd65536;
         ptr_ff    <= '0;
         loaded_ff <= 1'b0;
         ch_ff     <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
      end else begin
         ptr_ff    <= ptr_in;
         loaded_ff <= loaded_in;
         ch_ff     <= ch_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         if (wr) begin
            unique case (csr_index)
               rsz_pkg::REG_MODE:       mode_ff   <= csr_wdata[0];
               rsz_pkg::REG_IN_HEIGHT:  h_raw_ff  <= csr_wdata[7:0];
               rsz_pkg::REG_IN_WIDTH:   w_raw_ff  <= csr_wdata[7:0];
               rsz_pkg::REG_CHANNELS:   c_raw_ff  <= csr_wdata[2:0];
               rsz_pkg::REG_OUT_HEIGHT: oh_raw_ff <= csr_wdata[10:0];
               rsz_pkg::REG_OUT_WIDTH:  ow_raw_ff <= csr_wdata[10:0];
               rsz_pkg::REG_STEP_X:     sx_ff     <= csr_wdata;
               rsz_pkg::REG_STEP_Y:     sy_ff     <= csr_wdata;
               default:                 mode_ff   <= mode_ff;
            endcase
         end
      end
   end

endmodule

### sv/rsz_cmd_q.sv
// ----------------------------------------------------------------------------
// Resizer command queue
// Two-entry queue between front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsz_cmd_q (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_push,
   input  rsz_pkg::cmd_type q_din,
   output logic             q_full,
   input  logic             q_pop,
   output logic             q_empty,
   output rsz_pkg::cmd_type q_dout
);

   rsz_pkg::cmd_type slot_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign q_full  = (cnt_ff == 2'd2);
   assign q_empty = (cnt_ff == 2'd0);
   assign q_dout  = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (q_push) slot_ff[wp_ff] <= q_din;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (q_push) wp_ff <= ~wp_ff;
         if (q_pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, q_push} - {1'b0, q_pop};
      end
   end

   `ASSERT_NEVER(a_cnt_range, clock, reset, cnt_ff > 2'd2, "command queue count out of range")
   `ASSERT_NEVER(a_pop_empty, clock, reset, q_pop && q_empty, "pop from empty command queue")
   `ASSERT_NEVER(a_push_full, clock, reset, q_push && q_full, "push into full command queue")

endmodule

### sv/rsz_back.sv
// ----------------------------------------------------------------------------
// Resizer back end
// Owns the image store; writes loads and computes one output sample per
// emit by reading four neighbors through a shared multiply-accumulate.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsz_back (
   input  logic                clock,
   input  logic                reset,
   input  rsz_pkg::cfg_type    cfg,
   input  logic                q_empty,
   input  rsz_pkg::cmd_type    q_dout,
   output logic                q_pop,
   output logic                empty,
   input  logic                pop,
   output logic signed [15:0]  rsp_sample_out,
   output logic [1:0]          rsp_out_channel,
   output logic [9:0]          rsp_out_row,
   output logic [9:0]          rsp_out_col,
   output logic                rsp_last_pixel,
   output logic                rsp_data_valid
);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_IDX, S_ROW, S_RD, S_M1, S_M2, S_FIN
   } state_type;

   state_type        state_ff;
   rsz_pkg::cmd_type cmd_ff;
   logic [34:0] my_ff, mx_ff;
   logic [6:0]  y0_ff, y1_ff, x0_ff, x1_ff;
   logic [16:0] wy0_ff, wy1_ff, wx0_ff, wx1_ff;
   logic [14:0] ry0_ff, ry1_ff;
   logic [15:0] base_ff;
   logic [1:0]  k_ff;
   logic [32:0] t_ff;
   logic [47:0] acc_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_sample_ff;
   logic [1:0]  rsp_ch_ff;
   logic [9:0]  rsp_row_ff, rsp_col_ff;
   logic        rsp_last_ff, rsp_dv_ff;

   logic [15:0] mem [65536];
   logic [15:0] mem_q;
   logic [15:0] rd_addr;
   logic        mem_we, rsp_pop;

   logic [10:0] ay, ax;
   logic signed [35:0] py, px, sy, sx, hm2, wm1, wm2;
   logic [15:0] fy, fx;
   logic [6:0]  y0, y1, x0, x1;
   logic [16:0] wy0, wy1, wx0, wx1;
   logic [49:0] prod;
   logic [47:0] rnd;

   assign rsp_pop = pop && rsp_valid_ff;
   assign empty   = !rsp_valid_ff;
   assign q_pop   = (state_ff == S_IDLE) && !q_empty;
   assign mem_we  = q_pop && !q_dout.is_emit;

   assign ay = (cfg.mode == rsz_pkg::MODE_BILINEAR) ? {cmd_ff.row, 1'b1} : {1'b0, cmd_ff.row};
   assign ax = (cfg.mode == rsz_pkg::MODE_BILINEAR) ? {cmd_ff.col, 1'b1} : {1'b0, cmd_ff.col};

   // Source indexes and weights; nearest puts the whole weight on one tap.
   always_comb begin
      hm2 = $signed({28'd0, cfg.h}) - 36'sd2;
      wm1 = $signed({28'd0, cfg.w}) - 36'sd1;
      wm2 = $signed({28'd0, cfg.w}) - 36'sd2;
      py  = $signed({1'b0, my_ff}) - 36'sd65536;
      px  = $signed({1'b0, mx_ff}) - 36'sd65536;
      sy  = py >>> 17;
      sx  = px >>> 17;
      fy  = py[16:1];
      fx  = px[16:1];
      if (cfg.mode == rsz_pkg::MODE_BILINEAR) begin
         if (sy > hm2) sy = hm2;
         if (sy < 0) sy = '0;
         if (sx < 0) begin
            sx = '0;
            fx = '0;
         end
         if (sx >= wm1) begin
            fx = '0;
            sx = wm2;
         end
         if (sx < 0) sx = '0;
         y0 = sy[6:0];
         x0 = sx[6:0];
         y1 = ({1'b0, y0} + 8'd1 < cfg.h) ? y0 + 7'd1 : 7'(cfg.h - 8'd1);
         x1 = ({1'b0, x0} + 8'd1 < cfg.w) ? x0 + 7'd1 : 7'(cfg.w - 8'd1);
         wy1 = {1'b0, fy};
         wx1 = {1'b0, fx};
         wy0 = 17'd65536 - wy1;
         wx0 = 17'd65536 - wx1;
      end else begin
         y0 = (my_ff[34:16] > {11'd0, cfg.h - 8'd1}) ? 7'(cfg.h - 8'd1) : my_ff[22:16];
         x0 = (mx_ff[34:16] > {11'd0, cfg.w - 8'd1}) ? 7'(cfg.w - 8'd1) : mx_ff[22:16];
         y1  = y0;
         x1  = x0;
         wy0 = 17'd65536;
         wx0 = 17'd65536;
         wy1 = '0;
         wx1 = '0;
      end
   end

   assign rd_addr = base_ff + {1'b0, k_ff[0] ? ry1_ff : ry0_ff}
                  + {9'd0, k_ff[1] ? x1_ff : x0_ff};
   assign prod    = t_ff * (k_ff[0] ? wy1_ff : wy0_ff);
   assign rnd     = acc_ff + 48'h0000_8000_0000;

   // The store keeps samples in offset binary so the weighted sum stays unsigned.
   always_ff @(posedge clock) begin
      if (mem_we) mem[q_dout.addr] <= q_dout.sample ^ 16'h8000;
      mem_q <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_pop && state_ff != S_FIN) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (q_pop && q_dout.is_emit) begin
                  cmd_ff   <= q_dout;
                  acc_ff   <= '0;
                  state_ff <= q_dout.valid ? S_MUL : S_FIN;
               end
            end
            S_MUL: begin
               my_ff    <= {24'd0, ay} * {11'd0, cfg.step_y};
               mx_ff    <= {24'd0, ax} * {11'd0, cfg.step_x};
               state_ff <= S_IDX;
            end
            S_IDX: begin
               y0_ff <= y0;  y1_ff <= y1;  x0_ff <= x0;  x1_ff <= x1;
               wy0_ff <= wy0; wy1_ff <= wy1; wx0_ff <= wx0; wx1_ff <= wx1;
               state_ff <= S_ROW;
            end
            S_ROW: begin
               ry0_ff   <= {8'd0, y0_ff} * {7'd0, cfg.w};
               ry1_ff   <= {8'd0, y1_ff} * {7'd0, cfg.w};
               base_ff  <= {14'd0, cmd_ff.ch} * {1'b0, cfg.hw};
               k_ff     <= '0;
               state_ff <= S_RD;
            end
            S_RD: state_ff <= S_M1;
            S_M1: begin
               t_ff     <= mem_q * (k_ff[1] ? wx1_ff : wx0_ff);
               state_ff <= S_M2;
            end
            S_M2: begin
               acc_ff   <= acc_ff + prod[47:0];
               k_ff     <= k_ff + 2'd1;
               state_ff <= (k_ff == 2'd3) ? S_FIN : S_RD;
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_pop) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_sample_ff <= cmd_ff.valid ? (rnd[47:32] ^ 16'h8000) : 16'd0;
                  rsp_ch_ff     <= cmd_ff.ch;
                  rsp_row_ff    <= cmd_ff.row;
                  rsp_col_ff    <= cmd_ff.col;
                  rsp_last_ff   <= cmd_ff.last;
                  rsp_dv_ff     <= cmd_ff.valid;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_last_pixel  = rsp_last_ff;
   assign rsp_data_valid  = rsp_dv_ff;

   `ASSERT_AT(a_four_taps, clock, reset, (state_ff == S_M2 && k_ff == 2'd3) |=> state_ff == S_FIN, "tap loop did not finish after four taps")
   `ASSERT_AT(a_hold_result, clock, reset, (state_ff == S_FIN && rsp_valid_ff && !rsp_pop) |=> $stable(rsp_sample_ff) && rsp_valid_ff, "waiting result overwritten")
   `ASSERT_NEVER(a_write_idle, clock, reset, mem_we && state_ff != S_IDLE, "store written while busy")

endmodule

### sv/image_resize_bilinear_nearest_top.sv
// ----------------------------------------------------------------------------
// Image resizer, bilinear and nearest neighbor
// Front end classifies transactions, back end owns the store and the math.
//
//   channel   ports                                 direction
//   request   push/full, req_action, req_sample_in  in
//   response  empty/pop, rsp_*                      out
//   config    valid/ready, csr_index, csr_wdata     in
//
// A load is written to the store when the back end pops it; an emit runs
// the four taps in turn, as the store reads share one read port and one
// multiplier pair. An emit before the image is loaded skips the taps.
// Reset is synchronous; the store is not cleared.
// A two-entry command queue lets the front accept while the back works;
// one waiting result is held until popped.
// ----------------------------------------------------------------------------
module image_resize_bilinear_nearest_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic               req_action,
   input  logic signed [15:0] req_sample_in,
   output logic               empty,
   input  logic               pop,
   output logic signed [15:0] rsp_sample_out,
   output logic [1:0]         rsp_out_channel,
   output logic [9:0]         rsp_out_row,
   output logic [9:0]         rsp_out_col,
   output logic               rsp_last_pixel,
   output logic               rsp_data_valid,
   input  logic               valid,
   output logic               ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   rsz_pkg::cmd_type q_din, q_dout;
   rsz_pkg::cfg_type cfg;
   logic q_push, q_full, q_pop, q_empty;

   rsz_front u_front (
      .clock, .reset, .push, .full, .req_action, .req_sample_in,
      .valid, .ready, .csr_index, .csr_wdata,
      .q_full, .q_push, .q_cmd(q_din), .cfg
   );

   rsz_cmd_q u_q (
      .clock, .reset, .q_push, .q_din, .q_full, .q_pop, .q_empty, .q_dout
   );

   rsz_back u_back (
      .clock, .reset, .cfg, .q_empty, .q_dout, .q_pop, .empty, .pop,
      .rsp_sample_out, .rsp_out_channel, .rsp_out_row, .rsp_out_col,
      .rsp_last_pixel, .rsp_data_valid
   );

endmodule
